// ----- hdl/fwhi_pkg.sv -----
package fwhi_pkg;

    localparam int unsigned CNT_W       = 8;
    localparam int unsigned CAP_W       = 8;
    localparam int unsigned IN_DATA_W   = 32;
    localparam int unsigned OUT_VAL_W   = 32;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned USER_W      = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_ILV  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ODD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CP_RD,
        S_CP_WR,
        S_MG_RD,
        S_MG_WR0,
        S_MG_WR1
    } t_state;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_LOW,
        RD_HIGH
    } t_ent_rd_sel;

    typedef enum logic [1:0] {
        WR_PUSH,
        WR_EVEN,
        WR_ODD
    } t_ent_wr_sel;

    typedef struct packed {
        logic        enq;
        logic        deq;
        logic        ent_rd_en;
        t_ent_rd_sel ent_rd_sel;
        logic        ent_wr_en;
        t_ent_wr_sel ent_wr_sel;
        logic        scr_wr_en;
        logic        scr_rd_en;
        logic        idx_clr;
        logic        idx_inc;
        logic        load_out;
        logic        out_mem;
        t_status     status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic odd;
        logic last;
    } t_dp_stat;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] read_value;
        t_status              status;
        logic [CNT_W-1:0]     occupancy;
        logic                 empty_flag;
        logic                 full_flag;
    } t_result;

endpackage

// ----- hdl/fwhi_ctrl.sv -----
module fwhi_ctrl
    import fwhi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_opcode  i_op,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_valid && i_out_free) begin
                    case (i_op)
                        OP_ENQ: begin
                            o_cmd.load_out = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.enq        = 1'b1;
                                o_cmd.ent_wr_en  = 1'b1;
                                o_cmd.ent_wr_sel = WR_PUSH;
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (i_stat.empty) begin
                                o_cmd.load_out = 1'b1;
                                o_cmd.status   = ST_EMPTY;
                            end else begin
                                o_cmd.ent_rd_en  = 1'b1;
                                o_cmd.ent_rd_sel = RD_HEAD;
                                o_cmd.deq        = (i_op == OP_DEQ);
                                n_state          = S_READ;
                            end
                        end
                        OP_ILV: begin
                            if (i_stat.odd) begin
                                o_cmd.load_out = 1'b1;
                                o_cmd.status   = ST_ODD;
                            end else if (i_stat.empty) begin
                                o_cmd.load_out = 1'b1;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_CP_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_mem  = 1'b1;
                n_state        = S_IDLE;
            end
            S_CP_RD: begin
                o_cmd.ent_rd_en  = 1'b1;
                o_cmd.ent_rd_sel = RD_LOW;
                n_state          = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.scr_wr_en = 1'b1;
                if (i_stat.last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_MG_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CP_RD;
                end
            end
            S_MG_RD: begin
                o_cmd.ent_rd_en  = 1'b1;
                o_cmd.ent_rd_sel = RD_HIGH;
                o_cmd.scr_rd_en  = 1'b1;
                n_state          = S_MG_WR0;
            end
            S_MG_WR0: begin
                o_cmd.ent_wr_en  = 1'b1;
                o_cmd.ent_wr_sel = WR_EVEN;
                n_state          = S_MG_WR1;
            end
            S_MG_WR1: begin
                o_cmd.ent_wr_en  = 1'b1;
                o_cmd.ent_wr_sel = WR_ODD;
                if (i_stat.last) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_MG_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_out_free)
        else $error("result loaded while output slot busy");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ent_rd_en && o_cmd.ent_rd_sel == RD_HEAD) |=> o_cmd.load_out && o_cmd.out_mem)
        else $error("head read not followed by result load");

    a_walk_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_RD) |-> !i_stat.empty && !i_stat.odd)
        else $error("interleave walk on empty or odd queue");

endmodule

// ----- hdl/fwhi_datapath.sv -----
module fwhi_datapath
    import fwhi_pkg::*;
#(
    parameter int unsigned DEPTH      = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CAP_W-1:0]     i_cfg_wr_data,
    input  t_dp_cmd              i_cmd,
    input  logic [IN_DATA_W-1:0] i_push,
    output t_dp_stat             o_stat,
    output t_result              o_res
);

    localparam int unsigned AW        = $clog2(DEPTH);
    localparam int unsigned PW        = AW + 1;
    localparam int unsigned HALF      = (DEPTH + 1) / 2;
    localparam int unsigned HW        = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int unsigned DEPTH_CAP = (DEPTH > 255) ? 255 : DEPTH;

    logic [DATA_WIDTH-1:0] r_ent_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_scr_mem [HALF];
    logic [DATA_WIDTH-1:0] r_ent_rdata;
    logic [DATA_WIDTH-1:0] r_scr_rdata;

    logic [CAP_W-1:0] r_cap;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [HW-1:0]    r_idx;

    logic [CAP_W-1:0]      eff_cap;
    logic [CNT_W-1:0]      half;
    logic [PW-1:0]         idx_off;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [PW-1:0] off);
        logic [PW-1:0] sum;
        sum = PW'(head) + off;
        if (sum >= PW'(DEPTH)) begin
            sum = sum - PW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign eff_cap = (r_cap > CAP_W'(DEPTH_CAP)) ? CAP_W'(DEPTH_CAP) : r_cap;
    assign half    = {1'b0, r_count[CNT_W-1:1]};
    assign idx_off = PW'(r_idx);

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count >= eff_cap);
    assign o_stat.odd   = r_count[0];
    assign o_stat.last  = ((CNT_W'(r_idx) + CNT_W'(1)) == half);

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        if (i_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
            n_head  = slot(r_head, PW'(1));
        end
    end

    always_comb begin
        case (i_cmd.ent_rd_sel)
            RD_HEAD: rd_addr = r_head;
            RD_LOW:  rd_addr = slot(r_head, idx_off);
            RD_HIGH: rd_addr = slot(r_head, PW'(half) + idx_off);
            default: rd_addr = r_head;
        endcase
    end

    always_comb begin
        case (i_cmd.ent_wr_sel)
            WR_PUSH: begin
                wr_addr = slot(r_head, PW'(r_count));
                wr_data = DATA_WIDTH'(signed'(i_push));
            end
            WR_EVEN: begin
                wr_addr = slot(r_head, idx_off << 1);
                wr_data = r_scr_rdata;
            end
            WR_ODD: begin
                wr_addr = slot(r_head, (idx_off << 1) + PW'(1));
                wr_data = r_ent_rdata;
            end
            default: begin
                wr_addr = r_head;
                wr_data = r_ent_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_wr_en) begin
            r_ent_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.ent_rd_en) begin
            r_ent_rdata <= r_ent_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scr_wr_en) begin
            r_scr_mem[r_idx] <= r_ent_rdata;
        end
        if (i_cmd.scr_rd_en) begin
            r_scr_rdata <= r_scr_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + HW'(1);
            end
        end
    end

    assign o_res.read_value = i_cmd.out_mem ? OUT_VAL_W'(signed'(r_ent_rdata)) : '0;
    assign o_res.status     = i_cmd.status;
    assign o_res.occupancy  = n_count;
    assign o_res.empty_flag = (n_count == '0);
    assign o_res.full_flag  = (n_count >= eff_cap);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("entry count above depth");

    a_no_enq_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq |-> !o_stat.full && !i_cmd.deq)
        else $error("enqueue while full or together with dequeue");

    a_scratch_in_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scr_rd_en || i_cmd.scr_wr_en) |-> (CNT_W'(r_idx) < half))
        else $error("scratch index beyond half count");

endmodule

// ----- hdl/fifo_with_half_interleave.sv -----
// channel  | direction | tdata (low bit first)                       | tuser
// s_axis   | in        | push_value[31:0]                            | opcode[1:0]
// m_axis   | out       | read_value[31:0], occupancy[39:32],          | status[1:0]
//          |           | empty_flag[40], full_flag[41], zero[47:42]   |
// cfg      | in        | i_cfg_wr_en / i_cfg_wr_data = capacity[7:0]  | -
//
// enqueue, failed commands and interleave of an empty queue end in the idle state;
// dequeue and peek pass through the read state (registered entry memory read);
// interleave of even n > 0 copies the low half to scratch, then merges both halves
// one result register sits at the output; a new command is taken in the idle
// state when the register is empty or being drained in the same cycle
// i_rst_n is synchronous active low; queue empties, capacity returns to 100,
// memory contents are not cleared
module fifo_with_half_interleave
    import fwhi_pkg::*;
#(
    parameter int unsigned DEPTH      = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_W-1:0]       i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // push_value
    input  logic [USER_W-1:0]      s_axis_tuser,  // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_value, occupancy, empty, full
    output logic [USER_W-1:0]      m_axis_tuser   // status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  res;
    logic     out_free;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [USER_W-1:0]      r_out_user;

    assign out_free = !r_out_valid || m_axis_tready;

    fwhi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (t_opcode'(s_axis_tuser)),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    fwhi_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_push        (s_axis_tdata),
        .o_stat        (stat),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_data <= {6'b0, res.full_flag, res.empty_flag, res.occupancy,
                           res.read_value};
            r_out_user <= res.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
